### rtl/core/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg: shared types and constants
// Field widths, lane order, lane latency and configuration register codes for
// the upwind saturation divergence block.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int SAT_W     = 18;
    localparam int VEL_W     = 32;
    localparam int FACTOR_W  = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int LANES     = 5;
    localparam int FACES     = 4;

    // saturation pipeline: square, products, denominator, range check, divider
    localparam int LANE_LAT  = FACTOR_W + 4;
    localparam int MERGE_LAT = 5;

    localparam int LANE_C = 0;
    localparam int LANE_W = 1;
    localparam int LANE_E = 2;
    localparam int LANE_N = 3;
    localparam int LANE_S = 4;

    localparam int FACE_W = 0;
    localparam int FACE_E = 1;
    localparam int FACE_N = 2;
    localparam int FACE_S = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VISC_RATIO   = 2'd0,
        CFG_INV_POROSITY = 2'd1,
        CFG_INV_MESH     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic                sat;
    } factor_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_west;
        logic signed [VEL_W-1:0] vel_east;
        logic signed [VEL_W-1:0] vel_north;
        logic signed [VEL_W-1:0] vel_south;
        logic [FACES-1:0]        bnd;
    } face_pkt_t;

endpackage

### rtl/core/usd_factor_lane.sv
// ----------------------------------------------------------------------------
// usd_factor_lane: fractional-flow factor pipeline
// Forms s^2 * inv_porosity / (s^2 + ratio * (1 - s)^2) for one saturation,
// with a restoring divider resolving one quotient bit per stage.
// ----------------------------------------------------------------------------
module usd_factor_lane
    import usd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [SAT_W-1:0] sat,
    input  logic [FACTOR_W-1:0]     ratio,
    input  logic [FACTOR_W-1:0]     inv_por,
    output factor_t                 result
);

    localparam int F   = FRAC_BITS;
    localparam int QB  = FACTOR_W;
    localparam int OW  = ((F > SAT_W - 1) ? F : SAT_W - 1) + 2;
    localparam int S2W = 2 * SAT_W;
    localparam int HW  = 2 * OW - F;
    localparam int RTW = FACTOR_W + HW + 1;
    localparam int NW  = S2W + FACTOR_W;
    localparam int DW  = ((RTW > S2W) ? RTW : S2W) + 1;
    localparam int CW  = ((NW - QB > DW) ? NW - QB : DW);

    logic [SAT_W-1:0]       s_mag;
    logic signed [OW-1:0]   oil;
    logic [OW-1:0]          a_mag;
    logic [2*OW-1:0]        a2;
    logic [S2W-1:0]         s2_next;
    logic [S2W-1:0]         s2a_reg;
    logic [HW-1:0]          hi_reg;
    logic [F-1:0]           lo_reg;

    logic [FACTOR_W+HW-1:0] rhi;
    logic [FACTOR_W+F-1:0]  rlo;
    logic [S2W-1:0]         s2b_reg;
    logic [RTW-1:0]         rt_reg;
    logic [NW-1:0]          numb_reg;

    logic [DW-1:0]          denc_reg;
    logic [NW-1:0]          numc_reg;

    logic [DW-1:0]          rem_reg  [0:QB-1];
    logic [DW-1:0]          den_reg  [0:QB-1];
    logic [QB-1:0]          nlo_reg  [0:QB-1];
    logic [QB-1:0]          quo_reg  [0:QB];
    logic                   sat_reg  [0:QB];
    logic                   zero_reg [0:QB];

    always_comb
    begin
        s_mag   = sat[SAT_W-1] ? SAT_W'(-sat) : SAT_W'(sat);
        oil     = (OW'(1) <<< F) - OW'(sat);
        a_mag   = oil[OW-1] ? OW'(-oil) : OW'(oil);
        a2      = (2*OW)'(a_mag) * (2*OW)'(a_mag);
        s2_next = S2W'(s_mag) * S2W'(s_mag);
        rhi     = (FACTOR_W+HW)'(ratio) * (FACTOR_W+HW)'(hi_reg);
        rlo     = (FACTOR_W+F)'(ratio) * (FACTOR_W+F)'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2a_reg  <= s2_next;
            hi_reg   <= a2[2*OW-1:F];
            lo_reg   <= a2[F-1:0];
            s2b_reg  <= s2a_reg;
            rt_reg   <= RTW'(rhi) + RTW'(rlo[FACTOR_W+F-1:F]);
            numb_reg <= NW'(s2a_reg) * NW'(inv_por);
            denc_reg <= DW'(s2b_reg) + DW'(rt_reg);
            numc_reg <= numb_reg;
            rem_reg[0]  <= DW'(numc_reg[NW-1:QB]);
            den_reg[0]  <= denc_reg;
            nlo_reg[0]  <= numc_reg[QB-1:0];
            quo_reg[0]  <= '0;
            sat_reg[0]  <= CW'(numc_reg[NW-1:QB]) >= CW'(denc_reg);
            zero_reg[0] <= (denc_reg == '0);
        end
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        logic [DW:0] trial;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[i], nlo_reg[i][QB-1-i]};
            ge    = trial >= {1'b0, den_reg[i]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i+1]  <= quo_reg[i] | (ge ? (QB'(1) << (QB-1-i)) : '0);
                sat_reg[i+1]  <= sat_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end

        if (i < QB - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? DW'(trial - {1'b0, den_reg[i]}) : DW'(trial);
                    den_reg[i+1] <= den_reg[i];
                    nlo_reg[i+1] <= nlo_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        result.sat = sat_reg[QB] & ~zero_reg[QB];
        if (zero_reg[QB])
            result.factor = '0;
        else if (sat_reg[QB])
            result.factor = '1;
        else
            result.factor = quo_reg[QB];
    end

endmodule

### rtl/core/usd_merge.sv
// ----------------------------------------------------------------------------
// usd_merge: upwind flux selection and divergence
// Picks the upwind factor per face (unit factor on boundary faces), sums the
// face fluxes, scales by the inverse mesh width and saturates the result.
// ----------------------------------------------------------------------------
module usd_merge
    import usd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    en,
    input  factor_t                 lane [0:LANES-1],
    input  face_pkt_t               face,
    input  logic [CFG_W-1:0]        inv_mesh,
    output logic signed [VEL_W-1:0] divergence,
    output logic [FACTOR_W-1:0]     center_factor,
    output logic                    overflow
);

    localparam int F    = FRAC_BITS;
    localparam int PW   = VEL_W + FACTOR_W + 1;
    localparam int SUMW = PW + 2;
    localparam int MW   = SUMW - F;
    localparam int SPL  = 21;
    localparam int MHW  = MW - SPL;
    localparam int PHW  = MHW + CFG_W;
    localparam int PLW  = SPL + CFG_W;
    localparam int LIM  = 2 * SPL;
    localparam int RW   = 64;

    function automatic logic signed [PW-1:0] flux(
        input logic signed [VEL_W-1:0] v,
        input logic                    bnd,
        input logic [FACTOR_W-1:0]     fpos,
        input logic [FACTOR_W-1:0]     fneg
    );
        logic [FACTOR_W-1:0]  f;
        logic signed [PW-1:0] p;
        f = v[VEL_W-1] ? fneg : fpos;
        if (bnd)
            p = PW'(v) <<< F;
        else
            p = PW'(v) * PW'($signed({1'b0, f}));
        return p;
    endfunction

    function automatic logic used_sat(
        input logic signed [VEL_W-1:0] v,
        input logic                    bnd,
        input logic                    spos,
        input logic                    sneg
    );
        return ~bnd & (v[VEL_W-1] ? sneg : spos);
    endfunction

    logic signed [PW-1:0]   flw_reg, fle_reg, fln_reg, fls_reg;
    logic                   ovf1_reg, ovf2_reg, ovf3_reg, ovf4_reg;
    logic [FACTOR_W-1:0]    fc1_reg, fc2_reg, fc3_reg, fc4_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [SUMW-1:0]        mag;
    logic [MW-1:0]          m_reg;
    logic                   neg3_reg, neg4_reg;
    logic [PHW-1:0]         phi_reg;
    logic [PLW-1:0]         plo_reg;
    logic                   big;
    logic [RW-1:0]          prod;
    logic [RW-1:0]          r;
    logic                   clip;
    logic [VEL_W-1:0]       div_next;
    logic signed [VEL_W-1:0] div_reg;
    logic [FACTOR_W-1:0]    cf_reg;
    logic                   ovf_reg;

    always_comb
    begin
        mag  = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
        big  = |phi_reg[PHW-1:LIM];
        prod = {phi_reg[LIM-1:0], SPL'(0)} + RW'(plo_reg);
        r    = prod >> F;
        if (neg4_reg)
            clip = big | (r > RW'(64'h8000_0000));
        else
            clip = big | (r > RW'(64'h7FFF_FFFF));
        if (clip)
            div_next = neg4_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (neg4_reg)
            div_next = -r[VEL_W-1:0];
        else
            div_next = r[VEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flw_reg  <= flux(face.vel_west, face.bnd[FACE_W],
                             lane[LANE_W].factor, lane[LANE_C].factor);
            fle_reg  <= flux(face.vel_east, face.bnd[FACE_E],
                             lane[LANE_C].factor, lane[LANE_E].factor);
            fln_reg  <= flux(face.vel_north, face.bnd[FACE_N],
                             lane[LANE_C].factor, lane[LANE_N].factor);
            fls_reg  <= flux(face.vel_south, face.bnd[FACE_S],
                             lane[LANE_S].factor, lane[LANE_C].factor);
            ovf1_reg <= lane[LANE_C].sat
                      | used_sat(face.vel_west, face.bnd[FACE_W],
                                 lane[LANE_W].sat, lane[LANE_C].sat)
                      | used_sat(face.vel_east, face.bnd[FACE_E],
                                 lane[LANE_C].sat, lane[LANE_E].sat)
                      | used_sat(face.vel_north, face.bnd[FACE_N],
                                 lane[LANE_C].sat, lane[LANE_N].sat)
                      | used_sat(face.vel_south, face.bnd[FACE_S],
                                 lane[LANE_S].sat, lane[LANE_C].sat);
            fc1_reg  <= lane[LANE_C].factor;

            sum_reg  <= (SUMW'(fle_reg) - SUMW'(flw_reg)) + (SUMW'(fln_reg) - SUMW'(fls_reg));
            ovf2_reg <= ovf1_reg;
            fc2_reg  <= fc1_reg;

            m_reg    <= mag[SUMW-1:F];
            neg3_reg <= sum_reg[SUMW-1];
            ovf3_reg <= ovf2_reg;
            fc3_reg  <= fc2_reg;

            phi_reg  <= PHW'(m_reg[MW-1:SPL]) * PHW'(inv_mesh);
            plo_reg  <= PLW'(m_reg[SPL-1:0]) * PLW'(inv_mesh);
            neg4_reg <= neg3_reg;
            ovf4_reg <= ovf3_reg;
            fc4_reg  <= fc3_reg;

            div_reg  <= div_next;
            cf_reg   <= fc4_reg;
            ovf_reg  <= ovf4_reg | clip;
        end
    end

    assign divergence    = div_reg;
    assign center_factor = cf_reg;
    assign overflow      = ovf_reg;

endmodule

### rtl/core/upwind_saturation_divergence.sv
// ----------------------------------------------------------------------------
// upwind_saturation_divergence: upwind flux divergence of one grid cell
// Five factor lanes feed a merge stage that forms the saturated divergence.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready, one grid cell each: five
//   saturations, four face velocities and the boundary face mask.
//   Results leave on out_valid/out_ready: divergence, centre factor and
//   the overflow flag, one result per request, in order.
//   Each request passes through the factor lanes (the restoring divider
//   resolving one quotient bit per stage) and then the merge.
//   Throughput is one request per cycle while the receiver does not stall;
//   every lane and the merge are fully pipelined.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops until out_ready returns.
//   Reset empties the pipeline and sets all three registers to 1.0.
//   Write registers through cfg_write/cfg_index/cfg_data only while no
//   request is in flight; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module upwind_saturation_divergence
    import usd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SAT_W-1:0] sat_center,
    input  logic signed [SAT_W-1:0] sat_west,
    input  logic signed [SAT_W-1:0] sat_east,
    input  logic signed [SAT_W-1:0] sat_north,
    input  logic signed [SAT_W-1:0] sat_south,
    input  logic signed [VEL_W-1:0] vel_west,
    input  logic signed [VEL_W-1:0] vel_east,
    input  logic signed [VEL_W-1:0] vel_north,
    input  logic signed [VEL_W-1:0] vel_south,
    input  logic [FACES-1:0]        boundary_faces,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VEL_W-1:0] divergence,
    output logic [FACTOR_W-1:0]     center_factor,
    output logic                    overflow
);

    localparam int LAT = LANE_LAT + MERGE_LAT;
    localparam logic [CFG_W-1:0] CFG_RESET_ONE = CFG_W'(1) << FRAC_BITS;

    logic [FACTOR_W-1:0]     ratio_reg;
    logic [FACTOR_W-1:0]     inv_por_reg;
    logic [CFG_W-1:0]        inv_mesh_reg;
    logic [LAT-1:0]          vld_reg;
    logic                    en;
    logic signed [SAT_W-1:0] sat_in [0:LANES-1];
    factor_t                 lane_res [0:LANES-1];
    face_pkt_t               face_in;
    face_pkt_t               dly_reg [0:LANE_LAT-1];

    assign en        = ~vld_reg[LAT-1] | out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg    <= FACTOR_W'(CFG_RESET_ONE);
            inv_por_reg  <= FACTOR_W'(CFG_RESET_ONE);
            inv_mesh_reg <= CFG_RESET_ONE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VISC_RATIO:   ratio_reg    <= cfg_data[FACTOR_W-1:0];
                CFG_INV_POROSITY: inv_por_reg  <= cfg_data[FACTOR_W-1:0];
                CFG_INV_MESH:     inv_mesh_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    always_comb
    begin
        sat_in[LANE_C]    = sat_center;
        sat_in[LANE_W]    = sat_west;
        sat_in[LANE_E]    = sat_east;
        sat_in[LANE_N]    = sat_north;
        sat_in[LANE_S]    = sat_south;
        face_in.vel_west  = vel_west;
        face_in.vel_east  = vel_east;
        face_in.vel_north = vel_north;
        face_in.vel_south = vel_south;
        face_in.bnd       = boundary_faces;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= face_in;
            for (int i = 1; i < LANE_LAT; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        usd_factor_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .sat     (sat_in[l]),
            .ratio   (ratio_reg),
            .inv_por (inv_por_reg),
            .result  (lane_res[l])
        );
    end

    usd_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk           (clk),
        .en            (en),
        .lane          (lane_res),
        .face          (dly_reg[LANE_LAT-1]),
        .inv_mesh      (inv_mesh_reg),
        .divergence    (divergence),
        .center_factor (center_factor),
        .overflow      (overflow)
    );

endmodule

### bench/upwind_saturation_divergence_tb.sv
// ----------------------------------------------------------------------------
// upwind_saturation_divergence_tb: self-checking bench for the divergence block
// Drives grid cells with random handshake gaps and long output stalls,
// predicts each result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module upwind_saturation_divergence_tb;
    import usd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [SAT_W-1:0] sat [LANES];
        logic signed [VEL_W-1:0] vel [FACES];
        logic [FACES-1:0]        bnd;
    } cell_t;

    typedef struct {
        logic [31:0]         div;
        logic [FACTOR_W-1:0] fc;
        logic                ovf;
    } flux_res_t;

    class flux_scoreboard;
        logic [23:0] visc;
        logic [23:0] inv_por;
        logic [31:0] inv_mesh;
        flux_res_t   pending [$];
        int          errors;
        int          checked;

        function new();
            visc = 24'h010000;
            inv_por = 24'h010000;
            inv_mesh = 32'h00010000;
            errors = 0;
            checked = 0;
        endfunction

        function automatic logic [23:0] factor(logic signed [SAT_W-1:0] s, output logic sat);
            longint unsigned s_mag, s2, a, a2, rt, den, num, q;
            longint oil;
            s_mag = (s < 0) ? -longint'(s) : longint'(s);
            s2 = s_mag * s_mag;
            oil = 65536 - longint'(s);
            a = (oil < 0) ? -oil : oil;
            a2 = a * a;
            rt = longint'(visc) * (a2 >> 16) + ((longint'(visc) * (a2 & 16'hFFFF)) >> 16);
            den = s2 + rt;
            num = s2 * longint'(inv_por);
            sat = 1'b0;
            if (den == 0)
                return '0;
            q = num / den;
            if (q > 64'hFFFFFF)
            begin
                sat = 1'b1;
                q = 64'hFFFFFF;
            end
            return q[23:0];
        endfunction

        function automatic longint face(longint v, logic b, logic [23:0] fp, logic sp,
                                        logic [23:0] fn, logic sn, inout logic ovf);
            if (b)
                return v * 65536;
            if (v >= 0)
            begin
                if (sp) ovf = 1'b1;
                return v * longint'(fp);
            end
            if (sn) ovf = 1'b1;
            return v * longint'(fn);
        endfunction

        function void note_request(cell_t c);
            logic [23:0] f [LANES];
            logic        s [LANES];
            logic        ovf;
            longint      fw, fe, fnn, fs, sum;
            longint unsigned m, m_hi, m_lo, p_hi, r;
            logic        neg;
            flux_res_t   e;
            for (int i = 0; i < LANES; i++)
                f[i] = factor(c.sat[i], s[i]);
            ovf = s[LANE_C];
            fw = face(c.vel[FACE_W], c.bnd[0], f[LANE_W], s[LANE_W], f[LANE_C], s[LANE_C], ovf);
            fe = face(c.vel[FACE_E], c.bnd[1], f[LANE_C], s[LANE_C], f[LANE_E], s[LANE_E], ovf);
            fnn = face(c.vel[FACE_N], c.bnd[2], f[LANE_C], s[LANE_C], f[LANE_N], s[LANE_N], ovf);
            fs = face(c.vel[FACE_S], c.bnd[3], f[LANE_S], s[LANE_S], f[LANE_C], s[LANE_C], ovf);
            sum = (fe - fw) + (fnn - fs);
            neg = sum < 0;
            m = (neg ? -sum : sum) >> 16;
            m_hi = m >> 21;
            m_lo = m & 64'h1FFFFF;
            p_hi = m_hi * longint'(inv_mesh);
            if (p_hi >= (64'd1 << 42))
                r = 64'd1 << 32;
            else
                r = ((p_hi << 21) + m_lo * longint'(inv_mesh)) >> 16;
            if (neg)
            begin
                if (r > (64'd1 << 31))
                begin
                    r = 64'd1 << 31;
                    ovf = 1'b1;
                end
                r = -r;
            end
            else if (r > 64'h7FFFFFFF)
            begin
                r = 64'h7FFFFFFF;
                ovf = 1'b1;
            end
            e.div = r[31:0];
            e.fc = f[LANE_C];
            e.ovf = ovf;
            pending.push_back(e);
        endfunction

        function void check_result(logic [31:0] d, logic [23:0] fc, logic o);
            flux_res_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (d !== e.div)
                report_mismatch($sformatf("divergence %h, want %h", d, e.div));
            if (fc !== e.fc)
                report_mismatch($sformatf("center_factor %h, want %h", fc, e.fc));
            if (o !== e.ovf)
                report_mismatch($sformatf("overflow %b, want %b", o, e.ovf));
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("%0t mismatch: %s", $time, msg);
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [SAT_W-1:0] sat_center, sat_west, sat_east, sat_north, sat_south;
    logic signed [VEL_W-1:0] vel_west, vel_east, vel_north, vel_south;
    logic [FACES-1:0]        boundary_faces;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [VEL_W-1:0] divergence;
    logic [FACTOR_W-1:0]     center_factor;
    logic                    overflow;

    flux_scoreboard sb;
    int  hold_off;
    int  cells_sent;

    upwind_saturation_divergence u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .sat_center(sat_center), .sat_west(sat_west), .sat_east(sat_east),
        .sat_north(sat_north), .sat_south(sat_south),
        .vel_west(vel_west), .vel_east(vel_east),
        .vel_north(vel_north), .vel_south(vel_south),
        .boundary_faces(boundary_faces),
        .out_valid(out_valid), .out_ready(out_ready),
        .divergence(divergence), .center_factor(center_factor), .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [SAT_W-1:0] pick_sat();
        case ($urandom_range(0, 9))
            0: return 18'sh20000;
            1: return 18'sh1FFFF;
            2: return 18'sh10000;
            3: return '0;
            4: return SAT_W'($urandom());
            default: return SAT_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic signed [VEL_W-1:0] pick_vel();
        case ($urandom_range(0, 7))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return '0;
            3: return VEL_W'($urandom());
            default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        endcase
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_VISC_RATIO:   sb.visc = val[23:0];
            CFG_INV_POROSITY: sb.inv_por = val[23:0];
            CFG_INV_MESH:     sb.inv_mesh = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_cell(cell_t c);
        int gap;
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sat_center <= c.sat[LANE_C];
        sat_west <= c.sat[LANE_W];
        sat_east <= c.sat[LANE_E];
        sat_north <= c.sat[LANE_N];
        sat_south <= c.sat[LANE_S];
        vel_west <= c.vel[FACE_W];
        vel_east <= c.vel[FACE_E];
        vel_north <= c.vel[FACE_N];
        vel_south <= c.vel[FACE_S];
        boundary_faces <= c.bnd;
        do @(posedge clk); while (!in_ready);
        sb.note_request(c);
        cells_sent++;
    endtask

    task automatic send_random(int n);
        cell_t c;
        repeat (n)
        begin
            for (int i = 0; i < LANES; i++) c.sat[i] = pick_sat();
            for (int i = 0; i < FACES; i++) c.vel[i] = pick_vel();
            c.bnd = FACES'($urandom());
            send_cell(c);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(divergence, center_factor, overflow);
    end

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 14) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        cell_t c;
        sb = new();
        hold_off = 0;
        cells_sent = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_VISC_RATIO;
        cfg_data = '0;
        in_valid = 1'b0;
        {sat_center, sat_west, sat_east, sat_north, sat_south} = '0;
        {vel_west, vel_east, vel_north, vel_south} = '0;
        boundary_faces = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cells at reset settings
        for (int k = 0; k < 20; k++)
        begin
            for (int i = 0; i < LANES; i++)
                c.sat[i] = (k % 4 == 0) ? 18'sh20000 : (k % 4 == 1) ? 18'sh1FFFF :
                           (k % 4 == 2) ? 18'sh10000 : 18'sh0;
            c.sat[LANE_C] = (k < 10) ? c.sat[LANE_C] : 18'sh08000;
            for (int i = 0; i < FACES; i++)
                c.vel[i] = (k % 3 == 0) ? 32'sh80000000 : (k % 3 == 1) ? 32'sh7FFFFFFF
                                                                      : -32'sh10000;
            c.vel[k % FACES] = -c.vel[k % FACES];
            c.bnd = k[3:0];
            send_cell(c);
        end
        drain();

        write_reg(CFG_VISC_RATIO, 32'h0);
        write_reg(CFG_INV_POROSITY, 32'hFFFFFF);
        write_reg(CFG_INV_MESH, 32'hFFFFFFFF);
        send_random(350);
        drain();

        write_reg(CFG_VISC_RATIO, 32'hFFFFFF);
        write_reg(CFG_INV_POROSITY, 32'h0);
        write_reg(CFG_INV_MESH, 32'h0);
        send_random(250);
        drain();

        write_reg(CFG_VISC_RATIO, 32'h0);
        write_reg(CFG_INV_POROSITY, 32'h1);
        write_reg(CFG_INV_MESH, 32'h1);
        send_random(150);
        drain();

        write_reg(CFG_VISC_RATIO, $urandom_range(0, 32'hFFFFFF));
        write_reg(CFG_INV_POROSITY, $urandom_range(32'h10000, 32'h40000));
        write_reg(CFG_INV_MESH, $urandom_range(32'h8000, 32'h100000));
        hold_off = 200;
        send_random(750);
        drain();

        $display("Covered %0d cells over five register settings with %0d results checked.",
                 cells_sent, sb.checked);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
